// ----- rtl/dq_pkg.sv -----
`default_nettype none

package dq_pkg;

    // Action codes on the input word
    typedef enum logic [1:0] {
        A_INS_REAR  = 2'd0,
        A_INS_FRONT = 2'd1,
        A_DEL_FRONT = 2'd2,
        A_DEL_REAR  = 2'd3
    } t_action;

    // Status codes on the result word
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

endpackage

`default_nettype wire

// ----- rtl/dq_ram.sv -----
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
`default_nettype none

// Double-ended queue of signed 32-bit words kept in a circular buffer RAM of
// DEPTH entries. Each input word inserts at the rear or front, or deletes the
// front or rear; each yields one result word with the status (done, refused
// because empty, refused because full), the count after the step, and the
// front and rear words (zero when the deque is empty). The two end words are
// cached in registers, so inserts, refused actions and deletes that leave at
// most one entry are answered on acceptance; a delete that leaves two or more
// entries goes through the read state, since the new end word comes from the
// RAM's registered read. One word is in flight at a time, and a new word is
// taken only when the output register is empty or its result is taken in the
// same cycle. No clearing pass runs after reset.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [1:0]   i_action,
    input  wire logic [31:0]  i_word_in,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [1:0]        o_status,
    output logic [4:0]        o_count,
    output logic              o_ends_valid,
    output logic [31:0]       o_front_word,
    output logic [31:0]       o_rear_word
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state              r_state;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       r_tail;
    logic [CW-1:0]       r_held;
    logic [WORD_W-1:0]   r_front;
    logic [WORD_W-1:0]   r_rear;
    logic                r_pend_front;

    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_ends;
    logic [WORD_W-1:0]   r_out_front;
    logic [WORD_W-1:0]   r_out_rear;

    logic                w_accept;
    logic                w_empty;
    logic                w_full;
    logic [AW-1:0]       n_head;
    logic [AW-1:0]       n_tail;
    logic [CW-1:0]       n_held;
    t_status             n_status;
    logic [WORD_W-1:0]   n_front;
    logic [WORD_W-1:0]   n_rear;
    logic                w_need_read;
    logic                w_read_front;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [AW-1:0]       w_rd_addr;
    logic [WORD_W-1:0]   w_rd_data;
    logic [CW+COUNT_W-1:0] w_held_ext;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    assign o_ready  = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_empty  = (r_held == '0);
    assign w_full   = (r_held == CW'(DEPTH));

    // Next pointers, status, RAM access and cached end words
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_held       = r_held;
        n_status     = ST_DONE;
        n_front      = r_front;
        n_rear       = r_rear;
        w_need_read  = 1'b0;
        w_read_front = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_tail;
        w_rd_addr    = r_head;
        unique case (t_action'(i_action))
            A_INS_REAR: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_wr_en   = w_accept;
                    w_wr_addr = r_tail;
                    n_tail    = f_inc(r_tail);
                    n_held    = r_held + CW'(1);
                    n_rear    = i_word_in;
                    if (w_empty) begin
                        n_front = i_word_in;
                    end
                end
            end
            A_INS_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_wr_en   = w_accept;
                    w_wr_addr = f_dec(r_head);
                    n_head    = f_dec(r_head);
                    n_held    = r_held + CW'(1);
                    n_front   = i_word_in;
                    if (w_empty) begin
                        n_rear = i_word_in;
                    end
                end
            end
            A_DEL_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head       = f_inc(r_head);
                    n_held       = r_held - CW'(1);
                    w_rd_addr    = f_inc(r_head);
                    w_read_front = 1'b1;
                    if (r_held == CW'(2)) begin
                        n_front = r_rear;
                    end else if (r_held != CW'(1)) begin
                        w_need_read = 1'b1;
                    end
                end
            end
            A_DEL_REAR: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_tail    = f_dec(r_tail);
                    n_held    = r_held - CW'(1);
                    w_rd_addr = f_dec(f_dec(r_tail));
                    if (r_held == CW'(2)) begin
                        n_rear = r_front;
                    end else if (r_held != CW'(1)) begin
                        w_need_read = 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign w_held_ext = {{COUNT_W{1'b0}}, n_held};

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_word_in),
        .i_rd_en   (w_accept && w_need_read),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // State, pointers, cached ends and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_head       <= n_head;
                        r_tail       <= n_tail;
                        r_held       <= n_held;
                        r_front      <= n_front;
                        r_rear       <= n_rear;
                        r_pend_front <= w_read_front;
                        r_out_status <= n_status;
                        r_out_count  <= w_held_ext[COUNT_W-1:0];
                        r_out_ends   <= (n_held != '0);
                        r_out_front  <= (n_held != '0) ? n_front : '0;
                        r_out_rear   <= (n_held != '0) ? n_rear : '0;
                        if (w_need_read) begin
                            r_state     <= S_READ;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    // New end word arrives from the RAM
                    if (r_pend_front) begin
                        r_front     <= w_rd_data;
                        r_out_front <= w_rd_data;
                    end else begin
                        r_rear     <= w_rd_data;
                        r_out_rear <= w_rd_data;
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_ends_valid = r_out_ends;
    assign o_front_word = r_out_front;
    assign o_rear_word  = r_out_rear;

endmodule

`default_nettype wire
